>>> sv/crc16_packet_frame_checker_top_macros.svh
// Assertion macros used by the frame checker RTL.
`ifndef CRC16_PACKET_FRAME_CHECKER_TOP_MACROS_SVH
`define CRC16_PACKET_FRAME_CHECKER_TOP_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define CPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define CPF_ASSERT_NEXT(lbl, pre, post, msg) \
  `CPF_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> sv/crc16pf_pkg.sv
// Shared types, constants and the CRC byte update of the frame checker.
package crc16pf_pkg;

  localparam logic [10:0] MAX_FRAME_BYTES = 11'd256;
  localparam logic [9:0]  POS_LIMIT       = 10'd1023;
  localparam logic [15:0] CRC_POLY        = 16'h8408;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [10:0] MIN_FRAME_BYTES = 11'd4;

  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCNT_W  = QAW + 1;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_TOO_SHORT = 3'd1,
    STS_LEN_ERR   = 3'd2,
    STS_CRC_ERR   = 3'd3,
    STS_TOO_LONG  = 3'd4
  } frame_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } item_kind_t;

  // One classified byte on its way from the front end to the back end.
  typedef struct packed {
    logic [7:0]    data;
    logic          covered;
    logic          last;
    logic          emit;
    frame_status_t pre_status;   // STS_OK here means the CRC decides
    logic [7:0]    cmd;
    logic [7:0]    len;
  } op_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] rem_in, input logic [7:0] b);
    logic [15:0] rem;
    rem = rem_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (rem[0]) begin
        rem = (rem >> 1) ^ CRC_POLY;
      end else begin
        rem = rem >> 1;
      end
    end
    return rem;
  endfunction

endpackage

>>> sv/crc16pf_front.sv
// Front end: tracks frame position, captures header bytes, classifies each byte.
module crc16pf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [7:0]         in_frame_byte,
  input  logic               in_frame_end,
  input  logic               q_full,
  output logic               q_push,
  output crc16pf_pkg::op_t   q_op
);
  import crc16pf_pkg::*;

  logic [9:0] pos_r, pos_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;

  logic [7:0]  eff_cmd;
  logic [7:0]  eff_len;
  logic [10:0] pos_ext;
  logic [10:0] total;
  logic [10:0] body_end;
  logic        in_body;
  frame_status_t pre_sts;

  assign q_push = in_push && !q_full;

  always_comb begin
    eff_cmd  = (pos_r == 10'd0) ? in_frame_byte : cmd_r;
    eff_len  = (pos_r == 10'd1) ? in_frame_byte : len_r;
    pos_ext  = {1'b0, pos_r};
    total    = pos_ext + 11'd1;
    body_end = 11'd2 + {3'b000, eff_len};
    in_body  = (pos_ext >= 11'd2) && (pos_ext < body_end);

    if (total > MAX_FRAME_BYTES) begin
      pre_sts = STS_TOO_LONG;
    end else if (total < MIN_FRAME_BYTES) begin
      pre_sts = STS_TOO_SHORT;
    end else if (total != (body_end + 11'd2)) begin
      pre_sts = STS_LEN_ERR;
    end else begin
      pre_sts = STS_OK;
    end

    q_op.data       = in_frame_byte;
    q_op.covered    = (pos_ext < 11'd2) || in_body;
    q_op.last       = in_frame_end;
    q_op.emit       = !in_frame_end && in_body && (pos_ext < MAX_FRAME_BYTES);
    q_op.pre_status = pre_sts;
    q_op.cmd        = eff_cmd;
    q_op.len        = eff_len;
  end

  always_comb begin
    pos_nxt = pos_r;
    cmd_nxt = cmd_r;
    len_nxt = len_r;
    if (q_push) begin
      if (in_frame_end) begin
        // rearm for the next frame
        pos_nxt = '0;
        cmd_nxt = '0;
        len_nxt = '0;
      end else begin
        pos_nxt = (pos_r < POS_LIMIT) ? pos_r + 10'd1 : POS_LIMIT;
        cmd_nxt = eff_cmd;
        len_nxt = eff_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cmd_r <= '0;
      len_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      cmd_r <= cmd_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

>>> sv/crc16pf_fifo.sv
// Short queue of classified bytes between the front and back ends.
module crc16pf_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  crc16pf_pkg::op_t wr_data,
  input  logic             pop,
  output crc16pf_pkg::op_t rd_data,
  output logic             full,
  output logic             empty
);
  import crc16pf_pkg::*;

  op_t               mem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push_ok;
  logic              pop_ok;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`include "crc16_packet_frame_checker_top_macros.svh"

  `CPF_ASSERT(a_count_bound, count_r <= QCNT_W'(QDEPTH), "queue fill exceeds depth")
  `CPF_ASSERT_NEXT(a_fill_up, push_ok && !pop_ok, count_r == $past(count_r) + 1'b1, "fill did not grow")
  `CPF_ASSERT_NEXT(a_drain, pop_ok && !push_ok, count_r == $past(count_r) - 1'b1, "fill did not shrink")

endmodule

>>> sv/crc16pf_back.sv
// Back end: runs the CRC, checks it on the last byte and holds the result register.
module crc16pf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  crc16pf_pkg::op_t q_op,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             out_pop,
  output logic             out_empty,
  output logic             out_item_kind,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_command_code,
  output logic [7:0]       out_payload_length,
  output logic [2:0]       out_frame_status
);
  import crc16pf_pkg::*;

  logic [15:0]   crc_r, crc_nxt;
  logic [15:0]   rx_r, rx_nxt;
  logic          valid_r, valid_nxt;
  item_kind_t    kind_r, kind_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    len_r, len_nxt;
  frame_status_t sts_r, sts_nxt;

  logic [15:0] crc_upd;
  logic [15:0] rx_upd;
  logic        slot_free;

  assign slot_free = !valid_r || out_pop;
  assign q_pop     = !q_empty && slot_free;

  always_comb begin
    crc_upd = q_op.covered ? crc_byte(crc_r, q_op.data) : crc_r;
    rx_upd  = {rx_r[7:0], q_op.data};
  end

  always_comb begin
    crc_nxt   = crc_r;
    rx_nxt    = rx_r;
    valid_nxt = valid_r && !out_pop;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    sts_nxt   = sts_r;
    if (q_pop) begin
      if (q_op.last) begin
        crc_nxt   = CRC_INIT;
        rx_nxt    = '0;
        valid_nxt = 1'b1;
        kind_nxt  = KIND_STATUS;
        byte_nxt  = '0;
        cmd_nxt   = q_op.cmd;
        len_nxt   = q_op.len;
        if (q_op.pre_status != STS_OK) begin
          sts_nxt = q_op.pre_status;
        end else if (crc_upd != rx_upd) begin
          sts_nxt = STS_CRC_ERR;
        end else begin
          sts_nxt = STS_OK;
        end
      end else begin
        crc_nxt = crc_upd;
        rx_nxt  = rx_upd;
        if (q_op.emit) begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_PAYLOAD;
          byte_nxt  = q_op.data;
          cmd_nxt   = '0;
          len_nxt   = '0;
          sts_nxt   = STS_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      rx_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      rx_r    <= rx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    cmd_r  <= cmd_nxt;
    len_r  <= len_nxt;
    sts_r  <= sts_nxt;
  end

  assign out_empty          = !valid_r;
  assign out_item_kind      = kind_r;
  assign out_payload_byte   = byte_r;
  assign out_command_code   = cmd_r;
  assign out_payload_length = len_r;
  assign out_frame_status   = sts_r;

endmodule

>>> sv/crc16_packet_frame_checker_top.sv
// Top level of the CRC-16 length-prefixed frame checker.
//
// Usage: push frame bytes on in_frame_byte with in_frame_end high on the last
// byte of each frame; a byte is taken when in_push is high and in_full is low.
// A frame is command, length, payload, then the CRC-16 high byte first.
// Results come out as a queue: while out_empty is low the oldest result sits
// on the out_ ports, and out_pop takes it. Payload bytes come out as kind 0
// items; the last byte of a frame yields one kind 1 status item with the
// command, the declared length and the frame status.
// Throughput: one byte per cycle unless the receiver stalls, set by the
// eight-bit CRC update in the back end. A byte that yields a result is written
// into the queue and then into the result register.
// Bytes that cause no result still pass through the queue.
// When the receiver stalls, the result register holds and a four-entry queue
// absorbs bytes; in_full rises once it fills and drops when it drains.
// Reset (rst_n low, synchronous) empties the queue and result register and
// rearms the frame state: position zero, CRC at 0xFFFF.
module crc16_packet_frame_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_frame_byte,
  input  logic       in_frame_end,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_item_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_command_code,
  output logic [7:0] out_payload_length,
  output logic [2:0] out_frame_status
);
  import crc16pf_pkg::*;

  // classified transaction into and out of the queue
  op_t  fe_op;
  op_t  be_op;
  logic fe_push;
  logic q_full;
  logic q_empty;
  logic be_pop;

  // Classify each byte against frame position and header.
  crc16pf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_frame_byte (in_frame_byte),
    .in_frame_end  (in_frame_end),
    .q_full        (q_full),
    .q_push        (fe_push),
    .q_op          (fe_op)
  );

  // Decouple the input side from result stalls.
  crc16pf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fe_push),
    .wr_data (fe_op),
    .pop     (be_pop),
    .rd_data (be_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Run the CRC and drive the result register.
  crc16pf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_op               (be_op),
    .q_empty            (q_empty),
    .q_pop              (be_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_item_kind      (out_item_kind),
    .out_payload_byte   (out_payload_byte),
    .out_command_code   (out_command_code),
    .out_payload_length (out_payload_length),
    .out_frame_status   (out_frame_status)
  );

  // Hold off the sender while the queue is full.
  assign in_full = q_full;

endmodule
